// ===== hw/rtl/drl_pkg.sv =====
package drl_pkg;

	// Most runs accepted in one list before the list is rejected.
	localparam int MAX_RUNS = 4096;
	// Run counter width; it must reach MAX_RUNS + 1.
	localparam int RUN_CNT_W = $clog2(MAX_RUNS + 2);

	// Result kinds.
	localparam logic KIND_RUN    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// List status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_HDR   = 3'd1;
	localparam logic [2:0] ST_TRUNC     = 3'd2;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;
	localparam logic [2:0] ST_NEGATIVE  = 3'd5;
	localparam logic [2:0] ST_TOO_MANY  = 3'd6;

	// One byte of the encoded run list.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	// One decoded run or one final list status.
	typedef struct packed {
		logic        result_kind;
		logic [63:0] run_clusters;
		logic [62:0] run_start;
		logic        run_sparse;
		logic [2:0]  status;
		logic        last_result;
	} out_word_t;

endpackage

// ===== hw/rtl/data_run_list_decoder.sv =====
// Channel  Direction  Handshake                    Word
// byte     in         byte_valid / byte_stall      drl_pkg::in_word_t
// result   out        result_valid / result_stall  drl_pkg::out_word_t
//
// A byte is decoded in the cycle after it is accepted, and its results are
// written into the four-word result queue once the queue has room for them.
// A byte yields at most two results, and a two-result byte always follows one
// with none, so one byte per cycle is sustained while result_stall stays low.
// byte_stall rises only when result_stall has left too little queue room.
// Reset clears the decoder state and empties the queue at once.
module data_run_list_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  drl_pkg::in_word_t  byte_word,
	output logic               result_valid,
	input  logic               result_stall,
	output drl_pkg::out_word_t result_word
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LEN    = 2'd1;
	localparam logic [1:0] PH_OFF    = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam int QDEPTH = 4;

	// Input register.
	logic              valid_s1;
	drl_pkg::in_word_t word_s1;

	// Decoder state.
	logic [1:0]                   phase_q;
	logic [3:0]                   len_w_q;
	logic [3:0]                   off_w_q;
	logic [3:0]                   idx_q;
	logic [63:0]                  len_acc_q;
	logic [63:0]                  off_acc_q;
	logic [62:0]                  start_q;
	logic [drl_pkg::RUN_CNT_W-1:0] run_cnt_q;

	// Next state and results of the registered byte.
	logic [1:0]                   phase_d;
	logic [3:0]                   len_w_d;
	logic [3:0]                   off_w_d;
	logic [3:0]                   idx_d;
	logic [63:0]                  len_acc_d;
	logic [63:0]                  off_acc_d;
	logic [62:0]                  start_d;
	logic [drl_pkg::RUN_CNT_W-1:0] run_cnt_d;
	drl_pkg::out_word_t           res0;
	drl_pkg::out_word_t           res1;
	logic [1:0]                   n_res;

	// Working values of the decode.
	logic [7:0]  b;
	logic        last;
	logic [3:0]  lw;
	logic [3:0]  ow;
	logic [3:0]  idx_inc;
	logic [63:0] shifted;
	logic [63:0] len_new;
	logic [63:0] off_new;
	logic [63:0] len_fin;
	logic [63:0] raw;
	logic [5:0]  sb_idx;
	logic [5:0]  ext_sh;
	logic [63:0] sum;
	logic [drl_pkg::RUN_CNT_W-1:0] cnt_inc;
	logic        do_complete;
	logic        ended;

	// Result queue.
	drl_pkg::out_word_t queue_q [QDEPTH];
	logic [1:0]         wr_ptr_q;
	logic [1:0]         rd_ptr_q;
	logic [2:0]         count_q;
	logic               pop;
	logic [2:0]         room_used;
	logic               fits;
	logic               s1_go;

	// Queue flow control.
	assign pop          = result_valid && !result_stall;
	assign room_used    = count_q - {2'b0, pop};
	assign fits         = ({1'b0, room_used} + {2'b0, n_res}) <= 4'(QDEPTH);
	assign s1_go        = valid_s1 && fits;
	assign byte_stall   = valid_s1 && !fits;
	assign result_valid = count_q != 3'd0;
	assign result_word  = queue_q[rd_ptr_q];

	// Input register load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_go) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			word_s1 <= byte_word;
		end
	end

	// Byte shift-in, offset sign extension, start sum and run count increment.
	always_comb begin
		b       = word_s1.data_byte;
		last    = word_s1.last_byte;
		lw      = b[3:0];
		ow      = b[7:4];
		idx_inc = idx_q + 4'd1;
		shifted = {56'b0, b} << {idx_q[2:0], 3'b000};
		len_new = len_acc_q | shifted;
		off_new = off_acc_q | shifted;
		len_fin = (phase_q == PH_LEN) ? len_new : len_acc_q;
		sb_idx  = 6'({off_w_q[2:0], 3'b000} - 6'd1);
		ext_sh  = {off_w_q[2:0], 3'b000};
		raw     = off_new;
		if (off_w_q < 4'd8 && off_new[sb_idx]) begin
			raw = off_new | (~64'd0 << ext_sh);
		end
		sum     = {1'b0, start_q} + raw;
		cnt_inc = run_cnt_q + 1'b1;
	end

	// Decode of the registered byte.
	always_comb begin
		phase_d     = phase_q;
		len_w_d     = len_w_q;
		off_w_d     = off_w_q;
		idx_d       = idx_q;
		len_acc_d   = len_acc_q;
		off_acc_d   = off_acc_q;
		start_d     = start_q;
		run_cnt_d   = run_cnt_q;
		res0        = '0;
		res1        = '0;
		n_res       = 2'd0;
		do_complete = 1'b0;
		ended       = 1'b0;

		unique case (phase_q)
			PH_HEADER: begin
				if (b == 8'd0) begin
					res0.result_kind = drl_pkg::KIND_STATUS;
					res0.status      = drl_pkg::ST_OK;
					n_res            = 2'd1;
					ended            = 1'b1;
				end else if (lw == 4'd0 || lw > 4'd8 || ow > 4'd8) begin
					res0.result_kind = drl_pkg::KIND_STATUS;
					res0.status      = drl_pkg::ST_BAD_HDR;
					n_res            = 2'd1;
					ended            = 1'b1;
				end else begin
					len_w_d   = lw;
					off_w_d   = ow;
					idx_d     = 4'd0;
					len_acc_d = 64'd0;
					off_acc_d = 64'd0;
					phase_d   = PH_LEN;
				end
			end
			PH_LEN: begin
				len_acc_d = len_new;
				idx_d     = idx_inc;
				if (idx_inc >= len_w_q) begin
					idx_d = 4'd0;
					if (off_w_q == 4'd0) begin
						do_complete = 1'b1;
					end else begin
						phase_d = PH_OFF;
					end
				end
			end
			PH_OFF: begin
				off_acc_d = off_new;
				idx_d     = idx_inc;
				if (idx_inc >= off_w_q) begin
					idx_d       = 4'd0;
					do_complete = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// Run completion: zero length, start range, then run count.
		if (do_complete) begin
			if (len_fin == 64'd0) begin
				res0.result_kind = drl_pkg::KIND_STATUS;
				res0.status      = drl_pkg::ST_ZERO_LEN;
				n_res            = 2'd1;
				ended            = 1'b1;
			end else if (off_w_q != 4'd0 && sum[63]) begin
				res0.result_kind = drl_pkg::KIND_STATUS;
				res0.status      = raw[63] ? drl_pkg::ST_NEGATIVE : drl_pkg::ST_OVERFLOW;
				n_res            = 2'd1;
				ended            = 1'b1;
			end else begin
				res0.result_kind  = drl_pkg::KIND_RUN;
				res0.run_clusters = len_fin;
				res0.run_sparse   = (off_w_q == 4'd0);
				if (off_w_q != 4'd0) begin
					start_d        = sum[62:0];
					res0.run_start = sum[62:0];
				end
				n_res     = 2'd1;
				run_cnt_d = cnt_inc;
				phase_d   = PH_HEADER;
				if (cnt_inc > drl_pkg::RUN_CNT_W'(drl_pkg::MAX_RUNS)) begin
					res1.result_kind = drl_pkg::KIND_STATUS;
					res1.status      = drl_pkg::ST_TOO_MANY;
					n_res            = 2'd2;
					ended            = 1'b1;
				end
			end
		end

		// End of buffer with no status yet.
		if (phase_q != PH_DONE && !ended && last) begin
			if (n_res == 2'd0) begin
				res0.result_kind = drl_pkg::KIND_STATUS;
				res0.status      = (phase_d == PH_HEADER) ? drl_pkg::ST_OK
				                                           : drl_pkg::ST_TRUNC;
			end else begin
				res1.result_kind = drl_pkg::KIND_STATUS;
				res1.status      = (phase_d == PH_HEADER) ? drl_pkg::ST_OK
				                                           : drl_pkg::ST_TRUNC;
			end
			n_res = n_res + 2'd1;
			ended = 1'b1;
		end

		// Mark the final result of this byte.
		if (n_res == 2'd1) begin
			res0.last_result = 1'b1;
		end else if (n_res == 2'd2) begin
			res1.last_result = 1'b1;
		end

		// After a status, wait for the end of the buffer, then clear the decoder state.
		if (ended || phase_q == PH_DONE) begin
			if (last) begin
				phase_d   = PH_HEADER;
				len_w_d   = 4'd0;
				off_w_d   = 4'd0;
				idx_d     = 4'd0;
				len_acc_d = 64'd0;
				off_acc_d = 64'd0;
				start_d   = 63'd0;
				run_cnt_d = '0;
			end else begin
				phase_d = PH_DONE;
			end
		end
	end

	// Decoder state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			len_w_q   <= 4'd0;
			off_w_q   <= 4'd0;
			idx_q     <= 4'd0;
			len_acc_q <= 64'd0;
			off_acc_q <= 64'd0;
			start_q   <= 63'd0;
			run_cnt_q <= '0;
		end else if (s1_go) begin
			phase_q   <= phase_d;
			len_w_q   <= len_w_d;
			off_w_q   <= off_w_d;
			idx_q     <= idx_d;
			len_acc_q <= len_acc_d;
			off_acc_q <= off_acc_d;
			start_q   <= start_d;
			run_cnt_q <= run_cnt_d;
		end
	end

	// Result queue pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (s1_go) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= room_used + (s1_go ? {1'b0, n_res} : 3'd0);
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (s1_go && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (s1_go && n_res == 2'd2) begin
			queue_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	// The queue never holds more words than it has.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(QDEPTH))
		else $error("result queue count exceeds its depth");

	// A byte is held back only when it waits in the input register and the result queue is not empty.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && count_q != 3'd0)
		else $error("byte stalled without a pending byte and a busy queue");

	// A live list never holds more runs than the limit.
	a_run_limit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DONE |-> run_cnt_q <= drl_pkg::RUN_CNT_W'(drl_pkg::MAX_RUNS))
		else $error("run count above limit while decoding");

endmodule

// ===== dv/tb.sv =====
module tb;

	localparam int CYCLE_LIMIT = 250000;
	localparam int PRINT_LIMIT = 40;

	typedef enum logic [1:0] {
		DEC_HEADER,
		DEC_LENGTH,
		DEC_OFFSET,
		DEC_IGNORE
	} dec_phase_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               byte_valid;
	logic               byte_stall;
	drl_pkg::in_word_t  byte_word;
	logic               result_valid;
	logic               result_stall;
	drl_pkg::out_word_t result_word;

	data_run_list_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_word    (byte_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

	always #5 clk = ~clk;

	// Decoder state as the block should hold it.
	dec_phase_t  dec_phase;
	int          len_w;
	int          off_w;
	int          byte_idx;
	logic [63:0] len_acc;
	logic [63:0] off_acc;
	logic [62:0] run_origin;
	int          runs_in_list;

	// Words produced by the byte being decoded, then the queue of words still due.
	drl_pkg::out_word_t step_words [2];
	int                 step_n;
	logic               step_ended;
	drl_pkg::out_word_t decoded_q [$];

	// Bytes of the buffer being built for the next send.
	logic [7:0]  list_bytes [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int cycle_cnt = 0;
	int err_cnt = 0;
	int bytes_sent = 0;
	int lists_sent = 0;
	int runs_checked = 0;
	int statuses_checked = 0;
	drl_pkg::out_word_t want_word;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Add one byte at the end of the buffer being built.
	function automatic void add_byte(input logic [7:0] v);
		list_bytes.insert(list_bytes.size(), v);
	endfunction

	function automatic void clear_decoder();
		dec_phase = DEC_HEADER;
		len_w = 0;
		off_w = 0;
		byte_idx = 0;
		len_acc = '0;
		off_acc = '0;
		run_origin = '0;
		runs_in_list = 0;
	endfunction

	function automatic void add_word(input logic kind, input logic [63:0] clusters,
			input logic [62:0] start, input logic sparse, input logic [2:0] st);
		drl_pkg::out_word_t w;
		w = '0;
		w.result_kind = kind;
		w.run_clusters = clusters;
		w.run_start = start;
		w.run_sparse = sparse;
		w.status = st;
		step_words[step_n] = w;
		step_n++;
	endfunction

	function automatic void add_status(input logic [2:0] st);
		add_word(drl_pkg::KIND_STATUS, '0, '0, 1'b0, st);
		step_ended = 1'b1;
	endfunction

	// All bytes of a run are in: check its length and offset, emit it, then check the run count.
	function automatic void close_run();
		logic [63:0] raw;
		logic [63:0] sum;
		logic [62:0] start;
		int bits;
		start = '0;
		if (len_acc == 64'd0) begin
			add_status(drl_pkg::ST_ZERO_LEN);
			return;
		end
		if (off_w != 0) begin
			raw = off_acc;
			bits = 8 * off_w;
			if (off_w < 8 && raw[bits-1])
				raw = raw | ~((64'd1 << bits) - 64'd1);
			sum = {1'b0, run_origin} + raw;
			if (sum[63]) begin
				add_status(raw[63] ? drl_pkg::ST_NEGATIVE : drl_pkg::ST_OVERFLOW);
				return;
			end
			run_origin = sum[62:0];
			start = run_origin;
		end
		add_word(drl_pkg::KIND_RUN, len_acc, start, off_w == 0, drl_pkg::ST_OK);
		runs_in_list++;
		if (runs_in_list > drl_pkg::MAX_RUNS) begin
			add_status(drl_pkg::ST_TOO_MANY);
			return;
		end
		dec_phase = DEC_HEADER;
	endfunction

	// Advance the decoder by one accepted byte and queue the words it causes.
	function automatic void decode_byte(input logic [7:0] b, input logic is_last);
		logic [3:0] lw;
		logic [3:0] ow;
		int i;
		lw = b[3:0];
		ow = b[7:4];
		step_n = 0;
		step_ended = 1'b0;
		if (dec_phase == DEC_IGNORE) begin
			if (is_last)
				clear_decoder();
			return;
		end
		case (dec_phase)
			DEC_HEADER: begin
				if (b == 8'h00)
					add_status(drl_pkg::ST_OK);
				else if (lw == 4'd0 || lw > 4'd8 || ow > 4'd8)
					add_status(drl_pkg::ST_BAD_HDR);
				else begin
					len_w = int'(lw);
					off_w = int'(ow);
					byte_idx = 0;
					len_acc = '0;
					off_acc = '0;
					dec_phase = DEC_LENGTH;
				end
			end
			DEC_LENGTH: begin
				len_acc = len_acc | (64'(b) << (8 * byte_idx));
				byte_idx++;
				if (byte_idx >= len_w) begin
					byte_idx = 0;
					if (off_w == 0)
						close_run();
					else
						dec_phase = DEC_OFFSET;
				end
			end
			default: begin
				off_acc = off_acc | (64'(b) << (8 * byte_idx));
				byte_idx++;
				if (byte_idx >= off_w) begin
					byte_idx = 0;
					close_run();
				end
			end
		endcase
		if (!step_ended && is_last)
			add_status(dec_phase == DEC_HEADER ? drl_pkg::ST_OK : drl_pkg::ST_TRUNC);
		if (step_ended) begin
			if (is_last)
				clear_decoder();
			else
				dec_phase = DEC_IGNORE;
		end
		if (step_n > 0)
			step_words[step_n-1].last_result = 1'b1;
		for (i = 0; i < step_n; i++)
			decoded_q.insert(decoded_q.size(), step_words[i]);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (err_cnt < PRINT_LIMIT)
			$display("MISMATCH cycle %0d %s: got %0h, want %0h", cycle_cnt, what, got, want);
		err_cnt++;
	endtask

	// Offer one byte at the falling edge and hold it until it is taken.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_word <= '{data_byte: b, last_byte: is_last};
		do
			@(posedge clk);
		while (byte_stall);
		decode_byte(b, is_last);
		bytes_sent++;
	endtask

	task automatic send_list();
		int i;
		for (i = 0; i < list_bytes.size(); i++)
			send_byte(list_bytes[i], i == list_bytes.size() - 1);
		lists_sent++;
	endtask

	// Drop valid and let every due word come out before going on.
	task automatic wait_drained();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic append_run(input int lw, input int ow, input logic [63:0] len_val,
			input logic [63:0] off_val);
		int i;
		add_byte(8'((ow << 4) | lw));
		for (i = 0; i < lw; i++)
			add_byte(len_val[8*i +: 8]);
		for (i = 0; i < ow; i++)
			add_byte(off_val[8*i +: 8]);
	endtask

	// Many short runs, mostly sparse, with a small forward offset now and then.
	task automatic append_short_runs(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if (i % 50 == 49)
				append_run(1, 1, 64'($urandom_range(1, 255)), 64'($urandom_range(0, 127)));
			else
				append_run(1, 0, 64'($urandom_range(1, 255)), '0);
		end
	endtask

	// Build one buffer: random bytes alone, or mostly well-formed runs and then one of the ways a list can end.
	task automatic build_random_list();
		int n_runs;
		int lw;
		int ow;
		int pick;
		int k;
		logic [63:0] len_val;
		logic [63:0] off_val;
		logic [63:0] cap;
		logic [63:0] lim;
		logic [63:0] mag;
		logic [62:0] gen_start;
		list_bytes.delete();
		gen_start = '0;
		if ($urandom_range(0, 99) < 5) begin
			k = $urandom_range(1, 8);
			repeat (k) add_byte(8'($urandom));
			return;
		end
		n_runs = $urandom_range(0, 6);
		repeat (n_runs) begin
			lw = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			pick = $urandom_range(0, 99);
			ow = (pick < 20) ? 0 : (pick < 70) ? $urandom_range(1, 3) : $urandom_range(4, 8);
			len_val = rand64();
			off_val = '0;
			if (ow != 0) begin
				cap = 64'd1 << (8 * ow - 1);
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					off_val = (rand64() & (cap - 64'd1)) >> $urandom_range(0, 8 * ow - 1);
					gen_start = gen_start + off_val[62:0];
				end else if (pick < 85) begin
					lim = ({1'b0, gen_start} < cap) ? {1'b0, gen_start} : cap;
					mag = rand64() % (lim + 64'd1);
					off_val = -mag;
					gen_start = gen_start - mag[62:0];
				end else
					off_val = rand64();
			end
			append_run(lw, ow, len_val, off_val);
		end
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			add_byte(8'h00);
			repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
		end else if (pick < 65) begin
			if (list_bytes.size() == 0)
				add_byte(8'h00);
		end else if (pick < 78) begin
			// Cut the buffer inside a run.
			lw = $urandom_range(1, 8);
			ow = $urandom_range(0, 8);
			add_byte(8'((ow << 4) | lw));
			k = $urandom_range(0, lw + ow - 1);
			repeat (k) add_byte(8'($urandom));
		end else if (pick < 88) begin
			case ($urandom_range(0, 2))
				0: add_byte(8'($urandom_range(1, 15) << 4));
				1: add_byte(8'(($urandom_range(0, 15) << 4) | $urandom_range(9, 15)));
				default: add_byte(8'(($urandom_range(9, 15) << 4) |
					$urandom_range(1, 8)));
			endcase
			repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
		end else begin
			append_run($urandom_range(1, 3), $urandom_range(0, 2), '0, rand64() >> 8);
			repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
		end
	endtask

	// Each list end and error status but too many runs, one short buffer at a time.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		list_bytes = '{8'h00};
		send_list();
		list_bytes = '{8'h50, 8'hFF};
		send_list();
		list_bytes = '{8'h09};
		send_list();
		list_bytes = '{8'h91};
		send_list();
		list_bytes = '{8'h01, 8'h05};
		send_list();
		list_bytes = '{8'h21};
		send_list();
		list_bytes = '{8'h12, 8'h00, 8'h00, 8'hAB, 8'h33};
		send_list();
		list_bytes = '{8'h11, 8'h01, 8'hFF};
		send_list();
		// Start moves to the top cluster, then one more step past it.
		list_bytes = '{8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h7F, 8'h11, 8'h01, 8'h01};
		send_list();
		wait_drained();
	endtask

	task automatic test_random_lists(input int send_pct, input int recv_pct, input int n_bytes);
		int start_cnt;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start_cnt = bytes_sent;
		while (bytes_sent - start_cnt < n_bytes) begin
			build_random_list();
			send_list();
		end
		wait_drained();
	endtask

	// The receiver holds off long enough that the result queue fills.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		list_bytes.delete();
		append_short_runs(40);
		add_byte(8'h00);
		hold_left = 400;
		send_list();
		wait_drained();
	endtask

	// Receiver stall, driven at the falling edge.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Compare each accepted result word with the oldest one due.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (decoded_q.size() == 0)
				report_mismatch("word with none due, kind/status",
					64'({result_word.result_kind, result_word.status}), '0);
			else begin
				want_word = decoded_q.pop_front();
				if (result_word.result_kind !== want_word.result_kind)
					report_mismatch("result_kind", 64'(result_word.result_kind),
						64'(want_word.result_kind));
				if (result_word.run_clusters !== want_word.run_clusters)
					report_mismatch("run_clusters", result_word.run_clusters,
						want_word.run_clusters);
				if (result_word.run_start !== want_word.run_start)
					report_mismatch("run_start", 64'(result_word.run_start),
						64'(want_word.run_start));
				if (result_word.run_sparse !== want_word.run_sparse)
					report_mismatch("run_sparse", 64'(result_word.run_sparse),
						64'(want_word.run_sparse));
				if (result_word.status !== want_word.status)
					report_mismatch("status", 64'(result_word.status),
						64'(want_word.status));
				if (result_word.last_result !== want_word.last_result)
					report_mismatch("last_result", 64'(result_word.last_result),
						64'(want_word.last_result));
				if (want_word.result_kind == drl_pkg::KIND_RUN)
					runs_checked++;
				else
					statuses_checked++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_word = '0;
		clear_decoder();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_lists(20, 48, 285);
		test_random_lists(48, 20, 285);
		test_random_lists(0, 0, 285);
		test_backpressure();
		repeat (20) @(posedge clk);
		if (decoded_q.size() != 0)
			report_mismatch("words never produced", 64'(decoded_q.size()), '0);
		$display("Sent %0d bytes in %0d buffers under three idle mixes and a long hold.",
			bytes_sent, lists_sent);
		$display("Checked %0d runs and %0d statuses of good, cut and malformed lists.",
			runs_checked, statuses_checked);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
